// ----- hdl/hall_sensor_position_decoder_defines.svh -----
// assertion macros for the hall sensor position decoder
// included by the rtl files that carry concurrent checks; no other dependencies
`ifndef HALL_SENSOR_POSITION_DECODER_DEFINES_SVH
`define HALL_SENSOR_POSITION_DECODER_DEFINES_SVH
`ifndef SYNTH
// antecedent holds, consequent holds in the next cycle
`define HSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hall decoder check failed");
// antecedent holds, consequent holds in the same cycle
`define HSD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hall decoder check failed");
`else
`define HSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define HSD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/hsd_pkg.sv -----
// shared types, hall code constants and commutation tables
// used by hsd_step and the hall_sensor_position_decoder top level
package hsd_pkg;

   localparam int CodeWidth = 3;
   localparam int CountWidth = 32;
   localparam int DirWidth = 2;

   localparam logic [CodeWidth-1:0] CODE_LOW_INVALID  = 3'b000;
   localparam logic [CodeWidth-1:0] CODE_HIGH_INVALID = 3'b111;
   localparam logic [CodeWidth-1:0] CODE_001 = 3'b001;
   localparam logic [CodeWidth-1:0] CODE_010 = 3'b010;
   localparam logic [CodeWidth-1:0] CODE_011 = 3'b011;
   localparam logic [CodeWidth-1:0] CODE_100 = 3'b100;
   localparam logic [CodeWidth-1:0] CODE_101 = 3'b101;
   localparam logic [CodeWidth-1:0] CODE_110 = 3'b110;

   localparam logic signed [DirWidth-1:0] SIGN_RESET = 2'sb01;

   typedef struct packed {
      logic [CodeWidth-1:0]         prior_code;
      logic [CodeWidth-1:0]         last_code;
      logic [CountWidth-1:0]        sample_count;
      logic [CountWidth-1:0]        invalid_count;
      logic [CountWidth-1:0]        fault_count;
      logic signed [CountWidth-1:0] position;
      logic signed [DirWidth-1:0]   direction;
   } hsd_state_type;

   // forward order 011 -> 001 -> 101 -> 100 -> 110 -> 010 -> 011
   function automatic logic [CodeWidth-1:0] fwd_pred(input logic [CodeWidth-1:0] code);
      logic [CodeWidth-1:0] r;
      case (code)
         CODE_001: r = CODE_011;
         CODE_010: r = CODE_110;
         CODE_011: r = CODE_010;
         CODE_100: r = CODE_101;
         CODE_101: r = CODE_001;
         CODE_110: r = CODE_100;
         default:  r = CODE_LOW_INVALID;
      endcase
      return r;
   endfunction

   function automatic logic [CodeWidth-1:0] fwd_succ(input logic [CodeWidth-1:0] code);
      logic [CodeWidth-1:0] r;
      case (code)
         CODE_001: r = CODE_101;
         CODE_010: r = CODE_011;
         CODE_011: r = CODE_001;
         CODE_100: r = CODE_110;
         CODE_101: r = CODE_100;
         CODE_110: r = CODE_010;
         default:  r = CODE_LOW_INVALID;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/hall_sensor_position_decoder.sv -----
// top level of the three-phase hall sensor position decoder
// depends on hsd_pkg, hsd_step and hall_sensor_position_decoder_defines.svh
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  req_     | in        | three hall levels
//  rsp_     | out       | direction, position, counters, current/prev code
//  csr_     | in        | direction_sign, 2 bit signed
//
// one sample per cycle while the rsp side does not stall: a sample is registered
// in the input register, then the decode and 32-bit adds fold it into the state
// register, which is the result register. rsp_tvalid rises when the state register
// takes the result.
// synchronous reset clears the counters, code history and direction; sign to +1.
// a stalled rsp side holds the state; the input register still takes one sample.
`include "hall_sensor_position_decoder_defines.svh"

module hall_sensor_position_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // hall_a, hall_b, hall_c, 5 bits zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // step_direction, position_count, fault_count,
                                     // invalid_code_count, sample_count,
                                     // current_code, previous_code
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data     // direction_sign
);

   logic [hsd_pkg::CodeWidth-1:0]       code_ff, code_in;
   logic                                in_valid_ff, in_valid_in;
   logic                                out_valid_ff, out_valid_in;
   logic signed [hsd_pkg::DirWidth-1:0] sign_ff, sign_in;
   hsd_pkg::hsd_state_type              state_ff, state_in, state_nxt;
   logic                                advance;
   logic                                req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   hsd_step u_step (
      .state_cur (state_ff),
      .code      (code_ff),
      .dir_sign  (sign_ff),
      .state_nxt (state_nxt)
   );

   always_comb begin
      code_in      = req_take ? {req_tdata[0], req_tdata[1], req_tdata[2]} : code_ff;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      state_in     = advance ? state_nxt : state_ff;
      sign_in      = (csr_valid && csr_ready) ? csr_data : sign_ff;
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         sign_ff      <= hsd_pkg::SIGN_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         sign_ff      <= sign_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {state_ff.prior_code, state_ff.last_code, state_ff.sample_count,
                        state_ff.invalid_count, state_ff.fault_count,
                        state_ff.position, state_ff.direction};

   `HSD_ASSERT_NEXT(a_advance_gives_result, clock, reset, advance, rsp_tvalid)
   `HSD_ASSERT_NEXT(a_state_holds_when_idle, clock, reset, !advance, $stable(state_ff))
   `HSD_ASSERT_NEXT(a_sample_count_steps, clock, reset, advance,
      state_ff.sample_count == $past(state_ff.sample_count) + hsd_pkg::CountWidth'(1))
   `HSD_ASSERT_NEXT(a_invalid_keeps_direction, clock, reset,
      advance && (code_ff == hsd_pkg::CODE_LOW_INVALID ||
                  code_ff == hsd_pkg::CODE_HIGH_INVALID),
      $stable(state_ff.direction))

endmodule

// ----- hdl/hsd_step.sv -----
// next-state logic for one hall sample: direction, position, event counters and code history
// depends on hsd_pkg
module hsd_step (
   input  hsd_pkg::hsd_state_type                 state_cur,
   input  logic [hsd_pkg::CodeWidth-1:0]          code,
   input  logic signed [hsd_pkg::DirWidth-1:0]    dir_sign,
   output hsd_pkg::hsd_state_type                 state_nxt
);

   logic                                   code_invalid;
   logic signed [hsd_pkg::DirWidth-1:0]    neg_sign;
   logic signed [hsd_pkg::DirWidth-1:0]    dir_new;
   logic                                   fault_inc;
   logic                                   invalid_inc;

   assign code_invalid = (code == hsd_pkg::CODE_LOW_INVALID) ||
                         (code == hsd_pkg::CODE_HIGH_INVALID);
   assign neg_sign = hsd_pkg::DirWidth'(-dir_sign);

   always_comb begin
      dir_new     = state_cur.direction;
      fault_inc   = 1'b0;
      invalid_inc = 1'b0;
      if (code_invalid) begin
         fault_inc   = 1'b1;
         invalid_inc = 1'b1;
      end else if (state_cur.last_code == code) begin
         dir_new = '0;
      end else if (state_cur.last_code == hsd_pkg::fwd_pred(code)) begin
         dir_new = dir_sign;
      end else if (state_cur.last_code == hsd_pkg::fwd_succ(code)) begin
         dir_new = neg_sign;
      end else if (state_cur.sample_count != '0) begin
         // illegal jump, not counted on the first sample
         fault_inc = 1'b1;
      end
   end

   always_comb begin
      state_nxt.direction     = dir_new;
      state_nxt.position      = state_cur.position +
         {{(hsd_pkg::CountWidth-hsd_pkg::DirWidth){dir_new[hsd_pkg::DirWidth-1]}}, dir_new};
      state_nxt.fault_count   = state_cur.fault_count +
         {{(hsd_pkg::CountWidth-1){1'b0}}, fault_inc};
      state_nxt.invalid_count = state_cur.invalid_count +
         {{(hsd_pkg::CountWidth-1){1'b0}}, invalid_inc};
      state_nxt.sample_count  = state_cur.sample_count + hsd_pkg::CountWidth'(1);
      state_nxt.last_code     = code;
      state_nxt.prior_code    = state_cur.last_code;
   end

endmodule
